// ----- rtl/tess_pkg.sv -----
// ----------------------------------------------------------------------------
// tess_pkg
// Shared types and constants for the two-ended shared stack: action and
// status codes and the default store depth.
// ----------------------------------------------------------------------------
package tess_pkg;

	// default number of words in the shared store
	localparam int DEPTH_DEFAULT = 16;

	// requested operation
	typedef enum logic [1:0] {
		ACT_PUSH_FIRST  = 2'd0,
		ACT_PUSH_SECOND = 2'd1,
		ACT_POP_FIRST   = 2'd2,
		ACT_POP_SECOND  = 2'd3
	} act_t;

	// outcome reported with each result beat
	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_FULL       = 2'd1,
		ST_BOTH_EMPTY = 2'd2,
		ST_ONE_EMPTY  = 2'd3
	} status_t;

endpackage

// ----- rtl/tess_ram.sv -----
// ----------------------------------------------------------------------------
// tess_ram
// Shared word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tess_ram #(
	parameter int DEPTH = tess_pkg::DEPTH_DEFAULT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [31:0]       wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [31:0]       rdata
);

	logic [31:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/two_ended_shared_stack.sv -----
// ----------------------------------------------------------------------------
// two_ended_shared_stack
// Two stacks in one store: the first grows up from entry 0, the second
// grows down from the last entry.
//
// Usage:
//   An item (action, data_value) is taken at a rising edge with start high
//   and busy low. Exactly one result beat follows, marked by done for one
//   cycle, carrying status and both stack tops with their nonempty flags.
//   A push, a refused item or a pop that empties its stack gives its result
//   in the cycle after it is taken and busy stays low, so one such item can
//   be taken every cycle.
//   A pop that leaves its stack nonempty must fetch the new top from the
//   store through its registered read port: busy is high for one cycle
//   and the result beat follows the wait state, so no new item is taken
//   while such a pop is fetching.
//   The top of each stack is cached in a register; the store is only read
//   when a pop exposes an older entry.
//   Reset clears both counts and the control state; the store contents are
//   left as they are and are never read before being written.
//   The receiver cannot stall: each result beat is shown for one cycle only.
// ----------------------------------------------------------------------------
module two_ended_shared_stack #(
	parameter int DEPTH = tess_pkg::DEPTH_DEFAULT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [31:0] data_value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] first_top,
	output logic               first_nonempty,
	output logic signed [31:0] second_top,
	output logic               second_nonempty
);

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WAIT = 2'b10
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         first_count_q;
	logic [CW-1:0]         second_count_q;
	logic [31:0]           first_cache_q;
	logic [31:0]           second_cache_q;
	logic                  wait_second_q;
	logic                  done_q;
	tess_pkg::status_t     status_q;

	logic                  accept;
	logic [CW:0]           fill_sum;
	logic                  full;
	logic                  both_empty;
	tess_pkg::status_t     status_n;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [31:0]           mem_rdata;
	logic [CW-1:0]         second_wpos;
	logic [CW-1:0]         first_rpos;
	logic [CW-1:0]         second_rpos;

	assign busy   = (state_q == S_WAIT);
	assign accept = start && !busy;

	// occupancy checks
	assign fill_sum   = {1'b0, first_count_q} + {1'b0, second_count_q};
	assign full       = (fill_sum >= {1'b0, DEPTH_C});
	assign both_empty = (first_count_q == '0) && (second_count_q == '0);

	// store positions
	assign second_wpos = DEPTH_C - ONE_C - second_count_q;
	assign first_rpos  = first_count_q - TWO_C;
	assign second_rpos = (DEPTH_C - second_count_q) + ONE_C;

	// item decode
	always_comb begin
		status_n  = tess_pkg::ST_DONE;
		mem_we    = 1'b0;
		mem_waddr = first_count_q[AW-1:0];
		mem_re    = 1'b0;
		mem_raddr = first_rpos[AW-1:0];
		unique case (action)
			tess_pkg::ACT_PUSH_FIRST: begin
				if (full) begin
					status_n = tess_pkg::ST_FULL;
				end else begin
					mem_we = accept;
				end
			end
			tess_pkg::ACT_PUSH_SECOND: begin
				mem_waddr = second_wpos[AW-1:0];
				if (full) begin
					status_n = tess_pkg::ST_FULL;
				end else begin
					mem_we = accept;
				end
			end
			tess_pkg::ACT_POP_FIRST: begin
				if (both_empty) begin
					status_n = tess_pkg::ST_BOTH_EMPTY;
				end else if (first_count_q == '0) begin
					status_n = tess_pkg::ST_ONE_EMPTY;
				end else begin
					mem_re = accept && (first_count_q >= TWO_C);
				end
			end
			default: begin
				mem_raddr = second_rpos[AW-1:0];
				if (both_empty) begin
					status_n = tess_pkg::ST_BOTH_EMPTY;
				end else if (second_count_q == '0) begin
					status_n = tess_pkg::ST_ONE_EMPTY;
				end else begin
					mem_re = accept && (second_count_q >= TWO_C);
				end
			end
		endcase
	end

	// control state, status and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			first_count_q  <= '0;
			second_count_q <= '0;
			wait_second_q  <= 1'b0;
			done_q         <= 1'b0;
			status_q       <= tess_pkg::ST_DONE;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= status_n;
						done_q   <= !mem_re;
						if (mem_re) begin
							state_q <= S_WAIT;
						end
						wait_second_q <= (action == tess_pkg::ACT_POP_SECOND);
						if (status_n == tess_pkg::ST_DONE) begin
							unique case (action)
								tess_pkg::ACT_PUSH_FIRST:  first_count_q  <= first_count_q + ONE_C;
								tess_pkg::ACT_PUSH_SECOND: second_count_q <= second_count_q + ONE_C;
								tess_pkg::ACT_POP_FIRST:   first_count_q  <= first_count_q - ONE_C;
								default:                   second_count_q <= second_count_q - ONE_C;
							endcase
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

	// top caches: pushed word on push, fetched word after a pop
	always_ff @(posedge clk) begin
		if (accept && (status_n == tess_pkg::ST_DONE)) begin
			if (action == tess_pkg::ACT_PUSH_FIRST) begin
				first_cache_q <= data_value;
			end
			if (action == tess_pkg::ACT_PUSH_SECOND) begin
				second_cache_q <= data_value;
			end
		end
		if (busy) begin
			if (wait_second_q) begin
				second_cache_q <= mem_rdata;
			end else begin
				first_cache_q <= mem_rdata;
			end
		end
	end

	tess_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (data_value),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result beat
	assign done            = done_q;
	assign status          = status_q;
	assign first_nonempty  = (first_count_q != '0);
	assign second_nonempty = (second_count_q != '0);
	assign first_top       = first_nonempty ? first_cache_q : '0;
	assign second_top      = second_nonempty ? second_cache_q : '0;

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-ended shared stack. A mirror of both stacks
// predicts status, tops and nonempty flags for every accepted item and checks
// each done beat in order. A short directed run covers the empty and full
// refusals and the data extremes. Random runs then move between push-heavy,
// pop-heavy and balanced phases so that both the full and the empty corners
// come up many times. Start idles at random, with one long stretch where it
// never idles.
// ----------------------------------------------------------------------------

// expected contents of one result beat
typedef struct {
	tess_pkg::status_t  status;
	logic signed [31:0] first_top;
	logic               first_nonempty;
	logic signed [31:0] second_top;
	logic               second_nonempty;
} top_report_t;

// mirror of the shared store and both stack counts
class stack_mirror;
	localparam int DEPTH = tess_pkg::DEPTH_DEFAULT;

	logic signed [31:0] words [DEPTH];
	int                 lower_count;
	int                 upper_count;
	top_report_t        expected_tops [$];
	int                 errors;

	function new();
		lower_count = 0;
		upper_count = 0;
		errors = 0;
	endfunction

	task report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// apply one accepted item and queue the beat it should produce
	function void note_item(input tess_pkg::act_t act, input logic signed [31:0] val);
		top_report_t exp;
		bit          full;
		bit          both_empty;
		full = (lower_count + upper_count) >= DEPTH;
		both_empty = (lower_count == 0) && (upper_count == 0);
		exp.status = tess_pkg::ST_DONE;
		case (act)
			tess_pkg::ACT_PUSH_FIRST: begin
				if (full) begin
					exp.status = tess_pkg::ST_FULL;
				end else begin
					words[lower_count] = val;
					lower_count++;
				end
			end
			tess_pkg::ACT_PUSH_SECOND: begin
				if (full) begin
					exp.status = tess_pkg::ST_FULL;
				end else begin
					upper_count++;
					words[DEPTH - upper_count] = val;
				end
			end
			tess_pkg::ACT_POP_FIRST: begin
				if (both_empty)
					exp.status = tess_pkg::ST_BOTH_EMPTY;
				else if (lower_count == 0)
					exp.status = tess_pkg::ST_ONE_EMPTY;
				else
					lower_count--;
			end
			default: begin
				if (both_empty)
					exp.status = tess_pkg::ST_BOTH_EMPTY;
				else if (upper_count == 0)
					exp.status = tess_pkg::ST_ONE_EMPTY;
				else
					upper_count--;
			end
		endcase
		exp.first_nonempty = (lower_count != 0);
		exp.first_top = (lower_count != 0) ? words[lower_count - 1] : 32'sd0;
		exp.second_nonempty = (upper_count != 0);
		exp.second_top = (upper_count != 0) ? words[DEPTH - upper_count] : 32'sd0;
		expected_tops.push_back(exp);
	endfunction

	// compare one done beat with the oldest expectation
	task check_result(input tess_pkg::status_t st, input logic signed [31:0] ftop,
			input logic fne, input logic signed [31:0] stop, input logic sne);
		top_report_t exp;
		if (expected_tops.size() == 0) begin
			report_mismatch("done beat with no item pending");
			return;
		end
		exp = expected_tops.pop_front();
		if (st !== exp.status)
			report_mismatch($sformatf("status got %0d want %0d", st, exp.status));
		if (ftop !== exp.first_top)
			report_mismatch($sformatf("first_top got %0d want %0d", ftop, exp.first_top));
		if (fne !== exp.first_nonempty)
			report_mismatch($sformatf("first_nonempty got %0b want %0b", fne,
				exp.first_nonempty));
		if (stop !== exp.second_top)
			report_mismatch($sformatf("second_top got %0d want %0d", stop,
				exp.second_top));
		if (sne !== exp.second_nonempty)
			report_mismatch($sformatf("second_nonempty got %0b want %0b", sne,
				exp.second_nonempty));
	endtask
endclass

module testbench;

	localparam int DEPTH = tess_pkg::DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic signed [31:0] data_value;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] first_top;
	logic               first_nonempty;
	logic signed [31:0] second_top;
	logic               second_nonempty;

	stack_mirror mirror;
	bit          idle_on;
	int          cycles;

	two_ended_shared_stack DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.data_value      (data_value),
		.done            (done),
		.status          (status),
		.first_top       (first_top),
		.first_nonempty  (first_nonempty),
		.second_top      (second_top),
		.second_nonempty (second_nonempty)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// check result beats first, then note the item taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.check_result(tess_pkg::status_t'(status), first_top,
					first_nonempty, second_top, second_nonempty);
			if (start && !busy)
				mirror.note_item(tess_pkg::act_t'(action), data_value);
		end
	end

	// present one item at a falling edge and hold it until taken
	task automatic issue(input tess_pkg::act_t act, input logic signed [31:0] val);
		bit taken;
		start <= 1'b1;
		action <= act;
		data_value <= val;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		@(negedge clk);
		// random idle gap after the item is taken
		if (idle_on && $urandom_range(99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	function automatic logic signed [31:0] random_word();
		case ($urandom_range(9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// pick an action with the given percentage of pushes
	function automatic tess_pkg::act_t random_action(input int push_pct);
		bit to_second;
		to_second = 1'($urandom_range(1));
		if ($urandom_range(99) < push_pct)
			return to_second ? tess_pkg::ACT_PUSH_SECOND : tess_pkg::ACT_PUSH_FIRST;
		return to_second ? tess_pkg::ACT_POP_SECOND : tess_pkg::ACT_POP_FIRST;
	endfunction

	initial begin
		int push_pct;
		mirror = new();
		cycles = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		action = tess_pkg::ACT_PUSH_FIRST;
		data_value = 32'sd0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: pops on an empty store
		issue(tess_pkg::ACT_POP_FIRST, 32'sd5);
		issue(tess_pkg::ACT_POP_SECOND, -32'sd5);
		// extremes on the first stack, then pop of the empty second one
		issue(tess_pkg::ACT_PUSH_FIRST, WORD_MIN);
		issue(tess_pkg::ACT_PUSH_FIRST, WORD_MAX);
		issue(tess_pkg::ACT_POP_SECOND, 32'sd0);
		issue(tess_pkg::ACT_PUSH_SECOND, 32'sd0);
		issue(tess_pkg::ACT_PUSH_SECOND, -32'sd1);
		issue(tess_pkg::ACT_POP_FIRST, 32'sd0);
		// fill the store from both ends
		for (int i = 0; i < DEPTH - 3; i++)
			issue(i[0] ? tess_pkg::ACT_PUSH_SECOND : tess_pkg::ACT_PUSH_FIRST,
				random_word());
		// pushes refused on a full store, then pops off both ends
		issue(tess_pkg::ACT_PUSH_FIRST, WORD_MAX);
		issue(tess_pkg::ACT_PUSH_SECOND, WORD_MIN);
		issue(tess_pkg::ACT_POP_FIRST, 32'sd0);
		issue(tess_pkg::ACT_POP_SECOND, 32'sd0);

		// random phases of 50 items; blocks 10 to 15 run without idling
		for (int blk = 0; blk < 40; blk++) begin
			idle_on = !(blk >= 10 && blk < 16);
			case ($urandom_range(2))
				0: push_pct = 75;
				1: push_pct = 25;
				default: push_pct = 50;
			endcase
			for (int i = 0; i < 50; i++)
				issue(random_action(push_pct), random_word());
		end
		start <= 1'b0;

		// drain
		while (mirror.expected_tops.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mirror.expected_tops.size() != 0)
			mirror.report_mismatch("items left without a done beat");

		if (mirror.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
